[hw/rtl/sbi_pkg.sv]
`default_nettype none
package sbi_pkg;

	localparam int ADDR_W    = 25;
	localparam int OFS_W     = 24;
	localparam int STK_DEPTH = 8;
	localparam int STK_IDX_W = $clog2(STK_DEPTH);
	localparam int STK_CNT_W = $clog2(STK_DEPTH + 1);
	localparam int VIS_SPAN  = 65536;
	localparam int VIS_W     = $clog2(VIS_SPAN);
	localparam int Q_DEPTH   = 2;
	localparam int Q_IDX_W   = 1;
	localparam int Q_CNT_W   = 2;

	// event kinds
	localparam logic [4:0] K_NOTE      = 5'd0;
	localparam logic [4:0] K_REST      = 5'd1;
	localparam logic [4:0] K_PROGRAM   = 5'd2;
	localparam logic [4:0] K_CALL      = 5'd3;
	localparam logic [4:0] K_JUMP      = 5'd4;
	localparam logic [4:0] K_LOOPFOREV = 5'd5;
	localparam logic [4:0] K_PAN       = 5'd6;
	localparam logic [4:0] K_VOLUME    = 5'd7;
	localparam logic [4:0] K_TRANSPOSE = 5'd8;
	localparam logic [4:0] K_BEND      = 5'd9;
	localparam logic [4:0] K_BENDRANGE = 5'd10;
	localparam logic [4:0] K_EXPR      = 5'd11;
	localparam logic [4:0] K_TEMPO     = 5'd12;
	localparam logic [4:0] K_MODDEPTH  = 5'd13;
	localparam logic [4:0] K_PORTASW   = 5'd14;
	localparam logic [4:0] K_PORTATIME = 5'd15;
	localparam logic [4:0] K_RETURN    = 5'd16;
	localparam logic [4:0] K_END       = 5'd17;
	localparam logic [4:0] K_TIMEBASE  = 5'd18;
	localparam logic [4:0] K_GENERIC   = 5'd19;
	localparam logic [4:0] K_UNKNOWN   = 5'd20;
	localparam logic [4:0] K_OVERFLOW  = 5'd21;

	// opcodes
	localparam logic [7:0] OP_REST      = 8'h80;
	localparam logic [7:0] OP_PROGRAM   = 8'h81;
	localparam logic [7:0] OP_OPENTRACK = 8'h88;
	localparam logic [7:0] OP_JUMP      = 8'h89;
	localparam logic [7:0] OP_CALL      = 8'h8A;
	localparam logic [7:0] OP_RANDOM    = 8'hA0;
	localparam logic [7:0] OP_TIMEBASE  = 8'hB0;
	localparam logic [7:0] OP_PAN       = 8'hC0;
	localparam logic [7:0] OP_VOLUME    = 8'hC1;
	localparam logic [7:0] OP_TRANSPOSE = 8'hC3;
	localparam logic [7:0] OP_BEND      = 8'hC4;
	localparam logic [7:0] OP_BENDRANGE = 8'hC5;
	localparam logic [7:0] OP_NOTEWAIT  = 8'hC7;
	localparam logic [7:0] OP_MODDEPTH  = 8'hCA;
	localparam logic [7:0] OP_PORTASW   = 8'hCE;
	localparam logic [7:0] OP_PORTATIME = 8'hCF;
	localparam logic [7:0] OP_LOOPSTART = 8'hD4;
	localparam logic [7:0] OP_EXPR      = 8'hD5;
	localparam logic [7:0] OP_CTRL_LAST = 8'hD6;
	localparam logic [7:0] OP_MISC_D9   = 8'hD9;
	localparam logic [7:0] OP_MISC_DA   = 8'hDA;
	localparam logic [7:0] OP_MISC_DE   = 8'hDE;
	localparam logic [7:0] OP_MISC_DF   = 8'hDF;
	localparam logic [7:0] OP_VAR0      = 8'hE0;
	localparam logic [7:0] OP_TEMPO     = 8'hE1;
	localparam logic [7:0] OP_VAR1      = 8'hE3;
	localparam logic [7:0] OP_EXT       = 8'hF0;
	localparam logic [7:0] OP_LOOPEND   = 8'hFC;
	localparam logic [7:0] OP_RETURN    = 8'hFD;
	localparam logic [7:0] OP_PRINTVAR = 8'hFE;
	localparam logic [7:0] OP_END       = 8'hFF;
	localparam logic [7:0] OP_NOTE_LIM  = 8'h80;

	localparam logic [3:0] SUB_SHORT = 4'hE;
	localparam logic [3:0] SUB_LONG0 = 4'h8;
	localparam logic [3:0] SUB_LONG1 = 4'h9;

	localparam logic [1:0] CFG_BASE  = 2'd0;
	localparam logic [1:0] CFG_START = 2'd1;
	localparam logic [1:0] CFG_NWAIT = 2'd2;

	typedef struct packed {
		logic [4:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        len;
		logic [15:0]       va;
		logic [7:0]        vb;
		logic [15:0]       sv;
		logic              bend;
		logic [7:0]        barg;
		logic [27:0]       dur;
		logic [27:0]       adv;
		logic [ADDR_W-1:0] next;
		logic              halt;
	} evt_rec_t;

	typedef struct packed {
		logic [STK_CNT_W-1:0] depth;
		logic                 waiting;
		logic                 clearing;
	} front_stat_t;

	function automatic logic [2:0] fixed_len(input logic [7:0] op);
		logic [2:0] r;
		r = 3'd0;
		if (op == OP_OPENTRACK)
			r = 3'd4;
		else if (op inside {OP_JUMP, OP_CALL})
			r = 3'd3;
		else if (op inside {OP_VAR0, OP_TEMPO, OP_VAR1, OP_PRINTVAR})
			r = 3'd2;
		else if (op == OP_TIMEBASE || (op inside {[OP_PAN:OP_CTRL_LAST]} &&
				op != OP_TRANSPOSE && op != OP_BEND))
			r = 3'd1;
		else if (op inside {OP_MISC_D9, OP_MISC_DA, OP_MISC_DE, OP_MISC_DF})
			r = 3'd1;
		return r;
	endfunction

	function automatic logic var_arg(input logic [7:0] op);
		return op < OP_NOTE_LIM || op inside {OP_REST, OP_PROGRAM, OP_TRANSPOSE, OP_BEND};
	endfunction

endpackage
`default_nettype wire

[hw/rtl/sbi_if.sv]
`default_nettype none
interface sbi_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

interface sbi_event_if;
	logic               valid;
	logic               ready;
	logic [4:0]         event_kind;
	logic [24:0]        event_address;
	logic [3:0]         event_length;
	logic [15:0]        value_a;
	logic [7:0]         value_b;
	logic signed [15:0] signed_value;
	logic [27:0]        duration;
	logic [27:0]        time_advance;
	logic [24:0]        next_address;
	logic               halted;
	modport source(output valid, output event_kind, output event_address,
		output event_length, output value_a, output value_b, output signed_value,
		output duration, output time_advance, output next_address, output halted,
		input ready);
	modport sink(input valid, input event_kind, input event_address,
		input event_length, input value_a, input value_b, input signed_value,
		input duration, input time_advance, input next_address, input halted,
		output ready);
endinterface

interface sbi_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sbi_visited.sv]
`default_nettype none
module sbi_visited
	import sbi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [VIS_W-1:0] waddr,
	input  wire logic [VIS_W-1:0] raddr,
	output logic                  rdata,
	output logic                  busy
);

	logic             mem [VIS_SPAN];
	logic [VIS_W-1:0] clr_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == VIS_W'(VIS_SPAN - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= 1'b0;
		else if (we)
			mem[waddr] <= 1'b1;
		rdata <= mem[raddr];
	end

	assign busy = busy_q;

endmodule
`default_nettype wire

[hw/rtl/sbi_front.sv]
`default_nettype none
module sbi_front
	import sbi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_ready,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [OFS_W-1:0]  cfg_data,
	input  wire logic              q_full,
	output logic                   push,
	output evt_rec_t               rec,
	output logic                   vis_we,
	output logic [VIS_W-1:0]       vis_waddr,
	output logic [VIS_W-1:0]       vis_raddr,
	input  wire logic              vis_rdata,
	input  wire logic              vis_busy,
	output front_stat_t            stat
);

	logic [OFS_W-1:0]     base_q, base_d, start_ofs_q, start_ofs_d;
	logic [ADDR_W-1:0]    cur_q, cur_d, cstart_q, cstart_d, dest_q, dest_d;
	logic [7:0]           op_q, op_d, vel_q, vel_d;
	logic [3:0]           pos_q, pos_d, jlen_q, jlen_d;
	logic [31:0]          acc_q, acc_d;
	logic                 rnd_q, rnd_d, nw_q, nw_d, stop_q, stop_d, wait_q, wait_d;
	logic [STK_CNT_W-1:0] depth_q, depth_d;
	logic [ADDR_W-1:0]    stk_addr_q [STK_DEPTH];
	logic [7:0]           stk_cnt_q [STK_DEPTH];
	logic                 stk_we;
	logic [STK_IDX_W-1:0] stk_idx, top_idx;
	logic [ADDR_W-1:0]    stk_waddr;
	logic [7:0]           stk_wcnt;

	logic                 fire, cmp, done, ext_bad;
	logic [7:0]           b, op_c, vel_n;
	logic [31:0]          acc_c;
	logic [3:0]           n_c, k;
	logic [ADDR_W-1:0]    nxt, dest_c;
	logic signed [16:0]   sum;
	logic signed [15:0]   avg;
	logic [28:0]          arg;
	logic [27:0]          dur;
	logic [15:0]          a16;

	assign b          = data_byte;
	assign byte_ready = !vis_busy && !wait_q && !q_full;
	assign fire       = byte_valid && byte_ready;
	assign nxt        = cur_q + 1'b1;
	assign top_idx    = STK_IDX_W'(depth_q - 1'b1);
	assign vis_raddr  = wait_q ? dest_q[VIS_W-1:0] : dest_c[VIS_W-1:0];
	assign vis_waddr  = cur_q[VIS_W-1:0];

	always_comb begin
		base_d = base_q; start_ofs_d = start_ofs_q; cur_d = cur_q; cstart_d = cstart_q;
		dest_d = dest_q; op_d = op_q; vel_d = vel_q; pos_d = pos_q; jlen_d = jlen_q;
		acc_d = acc_q; rnd_d = rnd_q; nw_d = nw_q; stop_d = stop_q; wait_d = wait_q;
		depth_d = depth_q;
		stk_we = 1'b0; stk_idx = depth_q[STK_IDX_W-1:0]; stk_waddr = nxt; stk_wcnt = '0;
		cmp = 1'b0; done = 1'b0; ext_bad = 1'b0;
		op_c = op_q; acc_c = acc_q; n_c = pos_q + 1'b1; k = '0; vel_n = vel_q;
		vis_we = 1'b0; push = 1'b0; rec = '0;

		if (fire && !stop_q) begin
			cur_d = nxt;
			if (pos_q == '0) begin
				cstart_d = cur_q;
				op_d     = b;
				acc_d    = '0;
				vis_we   = 1'b1;
				pos_d    = 4'd1;
				if (!(var_arg(b) || b == OP_EXT || fixed_len(b) != '0)) begin
					cmp = 1'b1; op_c = b; acc_c = '0; n_c = 4'd1;
				end
			end else begin
				if (pos_q != 4'd15)
					pos_d = pos_q + 1'b1;
				if (var_arg(op_q)) begin
					if (op_q < OP_NOTE_LIM && pos_q == 4'd1) begin
						vel_d = b;
					end else begin
						k = pos_q - (op_q < OP_NOTE_LIM ? 4'd2 : 4'd1);
						if (rnd_q) begin
							acc_d = {acc_q[23:0], b};
							done  = k >= 4'd3;
						end else if (op_q == OP_TRANSPOSE || op_q == OP_BEND) begin
							acc_d = {24'd0, b};
							done  = 1'b1;
						end else begin
							acc_d = {4'd0, acc_q[20:0], b[6:0]};
							done  = !b[7] || k >= 4'd3;
						end
					end
				end else if (op_q == OP_EXT) begin
					acc_d = {acc_q[23:0], b};
					if (pos_q == 4'd1)
						vel_n = b;
					vel_d = vel_n;
					if (pos_q == 4'd1 && !(b[7:4] inside {SUB_SHORT, SUB_LONG0, SUB_LONG1})) begin
						ext_bad = 1'b1;
						pos_d   = '0;
					end else begin
						done = pos_q >= (vel_n[7:4] == SUB_SHORT ? 4'd3 : 4'd4);
					end
				end else begin
					acc_d = {acc_q[23:0], b};
					done  = pos_q >= {1'b0, fixed_len(op_q)};
				end
				if (done) begin
					cmp = 1'b1; acc_c = acc_d;
				end
			end
		end

		a16    = acc_c[15:0];
		dest_c = ADDR_W'(base_q) + ADDR_W'(acc_c[OFS_W-1:0]);
		sum    = 17'(signed'(acc_c[31:16])) + 17'(signed'(acc_c[15:0]));
		avg    = 16'((sum + 17'(sum[16])) >>> 1);
		arg    = rnd_q ? 29'(avg) : {1'b0, acc_c[27:0]};
		dur    = arg[28] ? '0 : arg[27:0];

		rec.addr = cstart_d;
		rec.len  = n_c;

		if (ext_bad) begin
			push = 1'b1; rec.kind = K_UNKNOWN; rec.len = 4'd2; rec.halt = 1'b1;
		end else if (cmp) begin
			pos_d = '0;
			push  = 1'b1;
			if (var_arg(op_c)) begin
				rnd_d = 1'b0;
				if (op_c < OP_NOTE_LIM) begin
					rec.kind = K_NOTE; rec.va = {8'd0, op_c}; rec.vb = vel_q;
					rec.dur = dur; rec.adv = nw_q ? dur : '0;
				end else if (op_c == OP_REST) begin
					rec.kind = K_REST; rec.dur = dur; rec.adv = dur;
				end else if (op_c == OP_PROGRAM) begin
					rec.kind = K_PROGRAM; rec.va = {8'd0, arg[7:0]};
				end else if (op_c == OP_TRANSPOSE) begin
					rec.kind = K_TRANSPOSE; rec.sv = 16'(signed'(arg[7:0]));
				end else begin
					rec.kind = K_BEND; rec.bend = 1'b1; rec.barg = arg[7:0];
				end
			end else begin
				case (op_c)
					OP_CALL: begin
						if (depth_q >= STK_CNT_W'(STK_DEPTH)) begin
							rec.kind = K_OVERFLOW; rec.halt = 1'b1;
						end else begin
							stk_we = 1'b1; stk_waddr = nxt; stk_wcnt = '0;
							depth_d = depth_q + 1'b1;
							cur_d = dest_c;
							rec.kind = K_CALL;
						end
					end
					OP_JUMP: begin
						// visited bit comes back next cycle
						push = 1'b0; wait_d = 1'b1; dest_d = dest_c; jlen_d = n_c;
					end
					OP_RANDOM: begin
						rnd_d = 1'b1; rec.kind = K_GENERIC;
					end
					OP_TIMEBASE:  begin rec.kind = K_TIMEBASE;  rec.va = a16; end
					OP_PAN:       begin rec.kind = K_PAN;       rec.va = a16; end
					OP_VOLUME:    begin rec.kind = K_VOLUME;    rec.va = a16; end
					OP_BENDRANGE: begin rec.kind = K_BENDRANGE; rec.va = a16; end
					OP_NOTEWAIT: begin
						nw_d = acc_c[7:0] != '0; rec.kind = K_GENERIC; rec.va = a16;
					end
					OP_MODDEPTH:  begin rec.kind = K_MODDEPTH;  rec.va = a16; end
					OP_PORTASW: begin
						rec.kind = K_PORTASW; rec.va = {15'd0, acc_c[7:0] != '0};
					end
					OP_PORTATIME: begin rec.kind = K_PORTATIME; rec.va = a16; end
					OP_LOOPSTART: begin
						if (depth_q >= STK_CNT_W'(STK_DEPTH)) begin
							rec.kind = K_OVERFLOW; rec.halt = 1'b1;
						end else begin
							stk_we = 1'b1; stk_waddr = nxt; stk_wcnt = acc_c[7:0];
							depth_d = depth_q + 1'b1;
							rec.kind = K_GENERIC; rec.va = a16;
						end
					end
					OP_EXPR:  begin rec.kind = K_EXPR;  rec.va = a16; end
					OP_TEMPO: begin rec.kind = K_TEMPO; rec.va = a16; end
					OP_LOOPEND: begin
						rec.kind = K_GENERIC;
						if (depth_q != '0) begin
							if (stk_cnt_q[top_idx] == '0) begin
								depth_d = depth_q - 1'b1;
							end else begin
								// repeat: count down, keep the entry
								stk_we = 1'b1; stk_idx = top_idx;
								stk_waddr = stk_addr_q[top_idx];
								stk_wcnt = stk_cnt_q[top_idx] - 1'b1;
								cur_d = stk_addr_q[top_idx];
								rec.kind = K_RETURN;
							end
						end
					end
					OP_RETURN: begin
						rec.kind = K_RETURN;
						if (depth_q != '0) begin
							depth_d = depth_q - 1'b1;
							cur_d = stk_addr_q[top_idx];
						end
					end
					OP_END: begin rec.kind = K_END; rec.halt = 1'b1; end
					default: begin
						if (op_c == OP_EXT || fixed_len(op_c) != '0) begin
							rec.kind = K_GENERIC; rec.va = a16;
						end else begin
							rec.kind = K_UNKNOWN; rec.halt = 1'b1;
						end
					end
				endcase
			end
		end else if (wait_q && !q_full) begin
			wait_d = 1'b0; push = 1'b1;
			rec.addr = cstart_q; rec.len = jlen_q;
			if (vis_rdata) begin
				rec.kind = K_LOOPFOREV; rec.halt = 1'b1;
			end else begin
				rec.kind = K_JUMP; cur_d = dest_q;
			end
		end

		if (push && rec.halt)
			stop_d = 1'b1;
		rec.next = cur_d;

		if (cfg_we) begin
			case (cfg_index)
				CFG_BASE: begin
					base_d = cfg_data;
					cur_d  = ADDR_W'(cfg_data) + ADDR_W'(start_ofs_q);
				end
				CFG_START: begin
					start_ofs_d = cfg_data;
					cur_d       = ADDR_W'(base_q) + ADDR_W'(cfg_data);
				end
				CFG_NWAIT: nw_d = cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0; start_ofs_q <= '0; cur_q <= '0; cstart_q <= '0;
			op_q <= '0; vel_q <= '0; pos_q <= '0; acc_q <= '0;
			rnd_q <= 1'b0; nw_q <= 1'b1; stop_q <= 1'b0; wait_q <= 1'b0;
			depth_q <= '0;
		end else begin
			base_q <= base_d; start_ofs_q <= start_ofs_d; cur_q <= cur_d;
			cstart_q <= cstart_d; op_q <= op_d; vel_q <= vel_d; pos_q <= pos_d;
			acc_q <= acc_d; rnd_q <= rnd_d; nw_q <= nw_d; stop_q <= stop_d;
			wait_q <= wait_d; depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		dest_q <= dest_d;
		jlen_q <= jlen_d;
		if (stk_we) begin
			stk_addr_q[stk_idx] <= stk_waddr;
			stk_cnt_q[stk_idx]  <= stk_wcnt;
		end
	end

	assign stat.depth    = depth_q;
	assign stat.waiting  = wait_q;
	assign stat.clearing = vis_busy;

endmodule
`default_nettype wire

[hw/rtl/sbi_queue.sv]
`default_nettype none
module sbi_queue
	import sbi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire evt_rec_t rec_in,
	input  wire logic     pop,
	output evt_rec_t      rec_out,
	output logic          not_empty,
	output logic          full
);

	evt_rec_t             mem [Q_DEPTH];
	logic [Q_IDX_W-1:0]   wptr_q, rptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0; rptr_q <= '0; cnt_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wptr_q] <= rec_in;
	end

	assign rec_out   = mem[rptr_q];
	assign not_empty = cnt_q != '0;
	assign full      = cnt_q == Q_CNT_W'(Q_DEPTH);

endmodule
`default_nettype wire

[hw/rtl/sbi_back.sv]
`default_nettype none
module sbi_back
	import sbi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_not_empty,
	input  wire evt_rec_t q_rec,
	output logic          pop,
	sbi_event_if.source   event_out
);

	logic        out_v_q;
	evt_rec_t    out_q;
	evt_rec_t    rec_c;
	logic        neg;
	logic [7:0]  mag;
	logic [12:0] x;
	logic [19:0] xr;
	logic [6:0]  q0, qc;
	logic [13:0] r;
	logic [13:0] bmag;
	logic [15:0] sv_c;

	// bend * 8191 / 127 = 64*m + floor(63*m / 127), sign applied after
	always_comb begin
		neg  = q_rec.barg[7];
		mag  = neg ? 8'(-q_rec.barg) : q_rec.barg;
		x    = 13'(mag) * 13'd63;
		xr   = 20'(x) * 20'd129;
		q0   = {1'b0, xr[20-1:14]};
		r    = 14'(x) - 14'(q0) * 14'd127;
		qc   = (r >= 14'd127) ? q0 + 1'b1 : q0;
		bmag = {mag[7:0], 6'd0} + 14'(qc);
		sv_c = q_rec.bend ? (neg ? 16'd0 - 16'(bmag) : 16'(bmag)) : q_rec.sv;
		rec_c    = q_rec;
		rec_c.sv = sv_c;
	end

	assign pop = q_not_empty && (!out_v_q || event_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (pop)
			out_v_q <= 1'b1;
		else if (event_out.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= rec_c;
	end

	assign event_out.valid         = out_v_q;
	assign event_out.event_kind    = out_q.kind;
	assign event_out.event_address = out_q.addr;
	assign event_out.event_length  = out_q.len;
	assign event_out.value_a       = out_q.va;
	assign event_out.value_b       = out_q.vb;
	assign event_out.signed_value  = out_q.sv;
	assign event_out.duration      = out_q.dur;
	assign event_out.time_advance  = out_q.adv;
	assign event_out.next_address  = out_q.next;
	assign event_out.halted        = out_q.halt;

endmodule
`default_nettype wire

[hw/rtl/sequence_bytecode_interpreter_top.sv]
`default_nettype none
// Music-sequence bytecode interpreter. Feed it the byte at next_address of the
// last event (base+start after reset or a config write); it takes one byte per
// cycle unless stalled by a full queue, a pending jump check or the map clear,
// and emits one event per completed command via a two-entry queue and an output
// register. A jump waits for the visited-map read. After reset the 65536-entry
// visited map is cleared, one entry per cycle; cfg writes are taken at any time.
module sequence_bytecode_interpreter_top
	import sbi_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sbi_byte_if.sink    byte_in,
	sbi_event_if.source event_out,
	sbi_cfg_if.sink     cfg
);

	logic             vis_we, vis_rdata, vis_busy;
	logic [VIS_W-1:0] vis_waddr, vis_raddr;
	logic             push, pop, q_full, q_not_empty;
	evt_rec_t         rec_in, rec_out;
	front_stat_t      f_stat;

	assign cfg.ready = 1'b1;

	sbi_visited u_visited (
		.clk(clk), .arst_n(arst_n), .we(vis_we), .waddr(vis_waddr),
		.raddr(vis_raddr), .rdata(vis_rdata), .busy(vis_busy)
	);

	sbi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_in.valid), .byte_ready(byte_in.ready),
		.data_byte(byte_in.data_byte),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.q_full(q_full), .push(push), .rec(rec_in),
		.vis_we(vis_we), .vis_waddr(vis_waddr), .vis_raddr(vis_raddr),
		.vis_rdata(vis_rdata), .vis_busy(vis_busy), .stat(f_stat)
	);

	sbi_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .rec_in(rec_in), .pop(pop),
		.rec_out(rec_out), .not_empty(q_not_empty), .full(q_full)
	);

	sbi_back u_back (
		.clk(clk), .arst_n(arst_n), .q_not_empty(q_not_empty), .q_rec(rec_out),
		.pop(pop), .event_out(event_out)
	);

`ifndef SYNTH
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.depth <= STK_CNT_W'(STK_DEPTH))
		else $error("return stack depth out of range");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.clearing |-> !byte_in.ready)
		else $error("byte taken during visited-map clear");
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.waiting |-> !byte_in.ready)
		else $error("byte taken while jump check pending");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("push into full event queue");
`endif

endmodule
`default_nettype wire

[tb/sbi_event_checker.sv]
`default_nettype none
module sbi_event_checker
	import sbi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sbi_byte_if  bi,
	sbi_event_if ev,
	sbi_cfg_if   cf,
	output int   mismatches,
	output int   pending
);

	typedef struct {
		logic [4:0]  kind;
		logic [24:0] addr;
		logic [3:0]  len;
		logic [15:0] va;
		logic [7:0]  vb;
		logic [15:0] sv;
		logic [27:0] dur;
		logic [27:0] adv;
		logic [24:0] next;
		logic        halt;
	} seq_event_t;

	seq_event_t events_due[$];

	logic [23:0] base, start;
	logic        nwait_init, nwait;
	logic [24:0] cur, cmd_start;
	logic [7:0]  op, vel;
	int          pos;
	logic [31:0] acc;
	logic        rnd, stopped;
	logic [24:0] ret_addr[STK_DEPTH];
	logic [7:0]  ret_count[STK_DEPTH];
	int          depth;
	bit          seen[VIS_SPAN];

	function automatic int arg_bytes(input logic [7:0] o);
		if (o == OP_OPENTRACK)
			return 4;
		if (o == OP_JUMP || o == OP_CALL)
			return 3;
		if (o == OP_VAR0 || o == OP_TEMPO || o == OP_VAR1 || o == OP_PRINTVAR)
			return 2;
		if (o == OP_TIMEBASE || (o >= OP_PAN && o <= OP_CTRL_LAST &&
				o != OP_TRANSPOSE && o != OP_BEND))
			return 1;
		if (o == OP_MISC_D9 || o == OP_MISC_DA || o == OP_MISC_DE || o == OP_MISC_DF)
			return 1;
		return 0;
	endfunction

	function automatic logic takes_var(input logic [7:0] o);
		return o < OP_NOTE_LIM || o == OP_REST || o == OP_PROGRAM ||
			o == OP_TRANSPOSE || o == OP_BEND;
	endfunction

	task automatic put_event(input logic [4:0] k, input int n, input logic [15:0] va,
			input logic [7:0] vb, input logic [15:0] sv, input logic [27:0] dur,
			input logic [27:0] adv, input logic halt);
		seq_event_t e;
		e.kind = k;
		e.addr = cmd_start;
		e.len  = n[3:0];
		e.va   = va;
		e.vb   = vb;
		e.sv   = sv;
		e.dur  = dur;
		e.adv  = adv;
		e.next = cur;
		e.halt = halt;
		events_due = {events_due, e};
		if (halt)
			stopped = 1'b1;
	endtask

	task automatic finish_cmd(input int n);
		int          a, t;
		logic [27:0] d;
		logic [24:0] dest;
		logic [15:0] a16;
		a16  = acc[15:0];
		dest = base + acc[23:0];
		pos  = 0;
		if (takes_var(op)) begin
			if (rnd)
				a = ($signed(acc[31:16]) + $signed(acc[15:0])) / 2;
			else
				a = int'(acc[27:0]);
			rnd = 1'b0;
			d = a < 0 ? 28'd0 : a[27:0];
			if (op < OP_NOTE_LIM)
				put_event(K_NOTE, n, {8'h0, op}, vel, 0, d, nwait ? d : 28'd0, 0);
			else if (op == OP_REST)
				put_event(K_REST, n, 0, 0, 0, d, d, 0);
			else if (op == OP_PROGRAM)
				put_event(K_PROGRAM, n, {8'h0, a[7:0]}, 0, 0, 0, 0, 0);
			else begin
				a = $signed(a[7:0]);
				if (op == OP_TRANSPOSE)
					put_event(K_TRANSPOSE, n, 0, 0, a[15:0], 0, 0, 0);
				else begin
					t = a * 8191 / 127;
					put_event(K_BEND, n, 0, 0, t[15:0], 0, 0, 0);
				end
			end
			return;
		end
		case (op)
			OP_CALL: begin
				if (depth >= STK_DEPTH)
					put_event(K_OVERFLOW, n, 0, 0, 0, 0, 0, 1);
				else begin
					ret_addr[depth]  = cur;
					ret_count[depth] = 8'd0;
					depth++;
					cur = dest;
					put_event(K_CALL, n, 0, 0, 0, 0, 0, 0);
				end
			end
			OP_JUMP: begin
				if (seen[dest[VIS_W-1:0]])
					put_event(K_LOOPFOREV, n, 0, 0, 0, 0, 0, 1);
				else begin
					cur = dest;
					put_event(K_JUMP, n, 0, 0, 0, 0, 0, 0);
				end
			end
			OP_RANDOM: begin
				rnd = 1'b1;
				put_event(K_GENERIC, n, 0, 0, 0, 0, 0, 0);
			end
			OP_TIMEBASE:  put_event(K_TIMEBASE, n, a16, 0, 0, 0, 0, 0);
			OP_PAN:       put_event(K_PAN, n, a16, 0, 0, 0, 0, 0);
			OP_VOLUME:    put_event(K_VOLUME, n, a16, 0, 0, 0, 0, 0);
			OP_BENDRANGE: put_event(K_BENDRANGE, n, a16, 0, 0, 0, 0, 0);
			OP_NOTEWAIT: begin
				nwait = acc[7:0] != 0;
				put_event(K_GENERIC, n, a16, 0, 0, 0, 0, 0);
			end
			OP_MODDEPTH:  put_event(K_MODDEPTH, n, a16, 0, 0, 0, 0, 0);
			OP_PORTASW:   put_event(K_PORTASW, n, {15'h0, acc[7:0] != 0}, 0, 0, 0, 0, 0);
			OP_PORTATIME: put_event(K_PORTATIME, n, a16, 0, 0, 0, 0, 0);
			OP_LOOPSTART: begin
				if (depth >= STK_DEPTH)
					put_event(K_OVERFLOW, n, 0, 0, 0, 0, 0, 1);
				else begin
					ret_addr[depth]  = cur;
					ret_count[depth] = acc[7:0];
					depth++;
					put_event(K_GENERIC, n, a16, 0, 0, 0, 0, 0);
				end
			end
			OP_EXPR:  put_event(K_EXPR, n, a16, 0, 0, 0, 0, 0);
			OP_TEMPO: put_event(K_TEMPO, n, a16, 0, 0, 0, 0, 0);
			OP_LOOPEND: begin
				if (depth == 0)
					put_event(K_GENERIC, n, 0, 0, 0, 0, 0, 0);
				else if (ret_count[depth-1] == 0) begin
					depth--;
					put_event(K_GENERIC, n, 0, 0, 0, 0, 0, 0);
				end else begin
					ret_count[depth-1]--;
					cur = ret_addr[depth-1];
					put_event(K_RETURN, n, 0, 0, 0, 0, 0, 0);
				end
			end
			OP_RETURN: begin
				if (depth != 0) begin
					depth--;
					cur = ret_addr[depth];
				end
				put_event(K_RETURN, n, 0, 0, 0, 0, 0, 0);
			end
			OP_END: put_event(K_END, n, 0, 0, 0, 0, 0, 1);
			default: begin
				if (op == OP_EXT || arg_bytes(op) != 0)
					put_event(K_GENERIC, n, a16, 0, 0, 0, 0, 0);
				else
					put_event(K_UNKNOWN, n, 0, 0, 0, 0, 0, 1);
			end
		endcase
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [24:0] addr;
		int          p, k, need;
		logic        done;
		if (stopped)
			return;
		addr = cur;
		cur  = addr + 25'd1;
		if (pos == 0) begin
			cmd_start = addr;
			op   = b;
			acc  = 0;
			seen[addr[VIS_W-1:0]] = 1'b1;
			pos  = 1;
			if (takes_var(b) || b == OP_EXT || arg_bytes(b) != 0)
				return;
			finish_cmd(1);
			return;
		end
		p = pos;
		if (pos < 15)
			pos++;
		if (takes_var(op)) begin
			if (op < OP_NOTE_LIM && p == 1) begin
				vel = b;
				return;
			end
			k = p - (op < OP_NOTE_LIM ? 2 : 1);
			if (rnd) begin
				acc  = (acc << 8) | b;
				done = k >= 3;
			end else if (op == OP_TRANSPOSE || op == OP_BEND) begin
				acc  = {24'h0, b};
				done = 1'b1;
			end else begin
				acc  = ((acc << 7) | b[6:0]) & 32'h0FFF_FFFF;
				done = !b[7] || k >= 3;
			end
		end else if (op == OP_EXT) begin
			acc = (acc << 8) | b;
			if (p == 1) begin
				vel = b;
				if (b[7:4] != SUB_SHORT && b[7:4] != SUB_LONG0 && b[7:4] != SUB_LONG1) begin
					pos = 0;
					put_event(K_UNKNOWN, 2, 0, 0, 0, 0, 0, 1);
					return;
				end
			end
			need = vel[7:4] == SUB_SHORT ? 3 : 4;
			done = p >= need;
		end else begin
			acc  = (acc << 8) | b;
			done = p >= arg_bytes(op);
		end
		if (done)
			finish_cmd(p + 1);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			mismatches++;
			$display("%0t: %s expected %h actual %h", $time, name, exp, act);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seq_event_t e;
		if (!arst_n) begin
			base = 0; start = 0; nwait_init = 1'b1; nwait = 1'b1;
			cur = 0; cmd_start = 0; op = 0; vel = 0; pos = 0; acc = 0;
			rnd = 0; stopped = 0; depth = 0;
			foreach (seen[i])
				seen[i] = 1'b0;
			events_due.delete();
			mismatches = 0;
		end else begin
			if (ev.valid && ev.ready) begin
				if (events_due.size() == 0) begin
					mismatches++;
					$display("%0t: event kind %0d at %h with nothing expected", $time,
						ev.event_kind, ev.event_address);
				end else begin
					e = events_due.pop_front();
					check_field("event_kind", e.kind, ev.event_kind);
					check_field("event_address", e.addr, ev.event_address);
					check_field("event_length", e.len, ev.event_length);
					check_field("value_a", e.va, ev.value_a);
					check_field("value_b", e.vb, ev.value_b);
					check_field("signed_value", e.sv, ev.signed_value[15:0]);
					check_field("duration", e.dur, ev.duration);
					check_field("time_advance", e.adv, ev.time_advance);
					check_field("next_address", e.next, ev.next_address);
					check_field("halted", e.halt, ev.halted);
				end
			end
			if (cf.valid && cf.ready) begin
				if (cf.index == CFG_BASE)
					base = cf.data;
				else if (cf.index == CFG_START)
					start = cf.data;
				if (cf.index == CFG_NWAIT) begin
					nwait_init = cf.data[0];
					nwait = nwait_init;
				end else if (cf.index == CFG_BASE || cf.index == CFG_START)
					cur = base + start;
			end
			if (bi.valid && bi.ready)
				decode_byte(bi.data_byte);
		end
		pending = events_due.size();
	end

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb
	import sbi_pkg::*;
();

	localparam logic [7:0] OP_UNDEF = 8'h82;
	localparam logic [3:0] SUB_BAD  = 4'h3;

	logic clk;
	logic arst_n;
	int   mismatches, pending;

	sbi_byte_if  bi();
	sbi_event_if ev();
	sbi_cfg_if   cf();

	sequence_bytecode_interpreter_top i_dut (
		.clk(clk), .arst_n(arst_n), .byte_in(bi), .event_out(ev), .cfg(cf)
	);

	sbi_event_checker i_chk (
		.clk(clk), .arst_n(arst_n), .bi(bi), .ev(ev), .cf(cf),
		.mismatches(mismatches), .pending(pending)
	);

	// shadow of the track position, used only to steer stimulus
	logic [24:0] m_cur;
	logic [23:0] m_base, m_start;
	bit          m_seen[VIS_SPAN];
	logic [24:0] m_ret[STK_DEPTH];
	logic [7:0]  m_cnt[STK_DEPTH];
	int          m_depth;
	bit          m_rnd;
	int          bytes_sent;
	bit          calm;
	bit          hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// event sink with random back-pressure
	initial begin
		int n;
		ev.ready = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = 400;
			end else if (calm || $urandom_range(0, 3) == 0)
				n = 0;
			else
				n = $urandom_range(0, 15);
			if (n > 0) begin
				ev.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			ev.ready <= 1'b1;
			do @(posedge clk); while (!(ev.valid && ev.ready));
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int n;
		n = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		if (n > 0) begin
			bi.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		bi.valid     <= 1'b1;
		bi.data_byte <= b;
		do @(posedge clk); while (!(bi.valid && bi.ready));
		m_cur = m_cur + 25'd1;
		bytes_sent++;
	endtask

	task automatic send_op(input logic [7:0] b);
		m_seen[m_cur[VIS_W-1:0]] = 1'b1;
		send_byte(b);
	endtask

	// variable-length argument in n groups, or four raw bytes after a random prefix
	task automatic send_arg(input logic [31:0] v, input int n);
		logic [7:0] g;
		if (m_rnd) begin
			for (int i = 3; i >= 0; i--)
				send_byte(v[8*i +: 8]);
			m_rnd = 1'b0;
		end else begin
			for (int i = 0; i < n; i++) begin
				g = {1'b0, v[7*(n-1-i) +: 7]};
				if (i < n - 1)
					g[7] = 1'b1;
				else if (n == 4)
					g[7] = v[31];
				send_byte(g);
			end
		end
	endtask

	task automatic cmd_varop(input logic [7:0] op, input logic [31:0] v, input int n);
		send_op(op);
		send_arg(v, n);
	endtask

	task automatic cmd_note(input logic [6:0] key, input logic [7:0] vel,
			input logic [31:0] v, input int n);
		send_op({1'b0, key});
		send_byte(vel);
		send_arg(v, n);
	endtask

	task automatic cmd_small(input logic [7:0] op, input logic [31:0] v);
		send_op(op);
		if (m_rnd) begin
			for (int i = 3; i >= 0; i--)
				send_byte(v[8*i +: 8]);
			m_rnd = 1'b0;
		end else
			send_byte(v[7:0]);
	endtask

	task automatic cmd_fixed(input logic [7:0] op, input int len, input logic [31:0] v);
		send_op(op);
		for (int i = len - 1; i >= 0; i--)
			send_byte(v[8*i +: 8]);
	endtask

	task automatic cmd_random_prefix();
		send_op(OP_RANDOM);
		m_rnd = 1'b1;
	endtask

	task automatic stack_push(input logic [7:0] cnt);
		if (m_depth < STK_DEPTH) begin
			m_ret[m_depth] = m_cur;
			m_cnt[m_depth] = cnt;
			m_depth++;
		end
	endtask

	task automatic cmd_call(input logic [23:0] ofs);
		cmd_fixed(OP_CALL, 3, ofs);
		stack_push(8'd0);
		m_cur = m_base + ofs;
	endtask

	task automatic cmd_jump(input logic [23:0] ofs);
		cmd_fixed(OP_JUMP, 3, ofs);
		m_cur = m_base + ofs;
	endtask

	// jump to an address whose visited bit is still clear
	task automatic cmd_jump_fresh();
		logic [23:0] ofs;
		logic [24:0] dest;
		m_seen[m_cur[VIS_W-1:0]] = 1'b1;
		do begin
			ofs  = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 255));
			dest = m_base + ofs;
		end while (m_seen[dest[VIS_W-1:0]]);
		cmd_jump(ofs);
	endtask

	task automatic cmd_loopstart(input logic [7:0] cnt);
		cmd_fixed(OP_LOOPSTART, 1, cnt);
		stack_push(cnt);
	endtask

	task automatic cmd_loopend();
		cmd_fixed(OP_LOOPEND, 0, 0);
		if (m_depth > 0) begin
			if (m_cnt[m_depth-1] == 0)
				m_depth--;
			else begin
				m_cnt[m_depth-1]--;
				m_cur = m_ret[m_depth-1];
			end
		end
	endtask

	task automatic cmd_return();
		cmd_fixed(OP_RETURN, 0, 0);
		if (m_depth > 0) begin
			m_depth--;
			m_cur = m_ret[m_depth];
		end
	endtask

	task automatic cmd_ext(input logic [3:0] sub_hi);
		send_op(OP_EXT);
		send_byte({sub_hi, 4'($urandom)});
		repeat (sub_hi == SUB_SHORT ? 2 : 3)
			send_byte(8'($urandom));
	endtask

	task automatic random_cmd();
		int          r;
		logic [7:0]  op;
		r = $urandom_range(0, 99);
		if (r < 24)
			cmd_note(7'($urandom), 8'($urandom), $urandom, $urandom_range(1, 4));
		else if (r < 31)
			cmd_varop(OP_REST, $urandom, $urandom_range(1, 4));
		else if (r < 35)
			cmd_varop(OP_PROGRAM, $urandom, $urandom_range(1, 4));
		else if (r < 39)
			cmd_small(OP_TRANSPOSE, $urandom);
		else if (r < 43)
			cmd_small(OP_BEND, $urandom);
		else if (r < 50)
			cmd_random_prefix();
		else if (r < 60) begin
			do op = 8'($urandom_range(OP_PAN, OP_CTRL_LAST));
			while (op == OP_TRANSPOSE || op == OP_BEND || op == OP_LOOPSTART);
			cmd_fixed(op, 1, $urandom);
		end else if (r < 66) begin
			case ($urandom_range(0, 5))
				0: cmd_fixed(OP_TIMEBASE, 1, $urandom);
				1: cmd_fixed(OP_OPENTRACK, 4, $urandom);
				2: cmd_fixed(OP_VAR0, 2, $urandom);
				3: cmd_fixed(OP_VAR1, 2, $urandom);
				4: cmd_fixed(OP_PRINTVAR, 2, $urandom);
				default: cmd_fixed(OP_TEMPO, 2, $urandom);
			endcase
		end else if (r < 68) begin
			case ($urandom_range(0, 3))
				0: op = OP_MISC_D9;
				1: op = OP_MISC_DA;
				2: op = OP_MISC_DE;
				default: op = OP_MISC_DF;
			endcase
			cmd_fixed(op, 1, $urandom);
		end else if (r < 73) begin
			case ($urandom_range(0, 2))
				0: cmd_ext(SUB_SHORT);
				1: cmd_ext(SUB_LONG0);
				default: cmd_ext(SUB_LONG1);
			endcase
		end else if (r < 78 && m_depth < STK_DEPTH)
			cmd_call($urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 255)));
		else if (r < 82)
			cmd_jump_fresh();
		else if (r < 87 && m_depth < STK_DEPTH)
			cmd_loopstart($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)));
		else if (r < 94)
			cmd_loopend();
		else
			cmd_return();
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] v);
		cf.valid <= 1'b1;
		cf.index <= idx;
		cf.data  <= v;
		do @(posedge clk); while (!(cf.valid && cf.ready));
	endtask

	task automatic configure(input logic [23:0] b, input logic [23:0] s, input logic nw);
		write_reg(CFG_BASE, b);
		write_reg(CFG_START, s);
		write_reg(CFG_NWAIT, {23'h0, nw});
		cf.valid <= 1'b0;
		m_base  = b;
		m_start = s;
		m_cur   = b + s;
	endtask

	// stop sending and wait for every outstanding event plus pipeline slack
	task automatic drain();
		bi.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int          target;
		logic [24:0] here;
		bi.valid = 1'b0; bi.data_byte = 8'h00;
		cf.valid = 1'b0; cf.index = CFG_BASE; cf.data = 24'h0;
		arst_n = 1'b0;
		calm = 1'b0; hold_req = 1'b0; m_rnd = 1'b0; m_depth = 0; bytes_sent = 0;
		m_cur = 0; m_base = 0; m_start = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(24'h0, 24'h0, 1'b1);

		// directed: edge values, most commands, special cases
		cmd_return();
		cmd_loopend();
		cmd_note(7'h00, 8'h00, 32'h0, 1);
		cmd_note(7'h7F, 8'hFF, 32'hFFFF_FFFF, 4);
		cmd_varop(OP_REST, 32'h7F, 1);
		cmd_varop(OP_PROGRAM, 32'h3FFF, 2);
		cmd_fixed(OP_PAN, 1, 32'hFF);
		cmd_fixed(OP_VOLUME, 1, 32'h0);
		cmd_small(OP_TRANSPOSE, 32'h80);
		cmd_small(OP_BEND, 32'h7F);
		cmd_small(OP_BEND, 32'h81);
		cmd_random_prefix();
		cmd_note(7'h3C, 8'h40, 32'h8000_8001, 4);   // negative average clamps to 0
		cmd_random_prefix();
		cmd_varop(OP_REST, 32'h7FFF_7FFF, 4);
		cmd_random_prefix();
		cmd_fixed(OP_PAN, 1, 32'h40);                // prefix stays pending
		cmd_small(OP_BEND, 32'h00FE_0000);
		cmd_random_prefix();
		cmd_small(OP_TRANSPOSE, 32'hFFFF_0001);
		cmd_fixed(OP_NOTEWAIT, 1, 32'h0);
		cmd_note(7'h40, 8'h7F, 32'h10, 1);
		cmd_fixed(OP_NOTEWAIT, 1, 32'h1);
		cmd_fixed(OP_TEMPO, 2, 32'hFFFF);
		cmd_fixed(OP_TIMEBASE, 1, 32'h30);
		cmd_fixed(OP_PORTASW, 1, 32'h0);
		cmd_fixed(OP_PORTASW, 1, 32'h5);
		cmd_fixed(OP_OPENTRACK, 4, 32'hFFFF_FFFF);
		cmd_ext(SUB_SHORT);
		cmd_ext(SUB_LONG1);
		cmd_loopstart(8'd2);
		cmd_note(7'h41, 8'h20, 32'h5, 1);
		repeat (3) cmd_loopend();
		cmd_call(24'h00_1234);
		cmd_note(7'h42, 8'h10, 32'h3, 1);
		cmd_return();
		cmd_jump_fresh();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(24'h0, 24'hFF_FFFF, 1'b0);
				1: configure(24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
				4: configure(24'hFF_FFFF, 24'h0, 1'b0);
				default: configure(24'($urandom), 24'($urandom), 1'($urandom));
			endcase
			calm = (ph == 2 || ph == 3);
			if (ph == 3)
				hold_req = 1'b1;   // sink stalls while bytes keep coming
			target = bytes_sent + 200;
			while (bytes_sent < target)
				random_cmd();
			calm = 1'b0;
			drain();
		end

		// one stopping command, then bytes that must be ignored
		case ($urandom_range(0, 4))
			0: cmd_fixed(OP_END, 0, 0);
			1: cmd_fixed(OP_UNDEF, 0, 0);
			2: begin
				send_op(OP_EXT);
				send_byte({SUB_BAD, 4'($urandom)});
			end
			3: begin
				here = m_cur;
				cmd_jump(24'(here - m_base));
			end
			default: begin
				while (m_depth < STK_DEPTH)
					cmd_loopstart(8'($urandom));
				cmd_loopstart(8'd1);
			end
		endcase
		repeat (4) send_byte(8'($urandom));
		drain();

		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
